// ===== design/tlc_pkg.sv =====
// Shared types and constants for the thick line capsule test.
// No dependencies; imported by every module of the block.
package tlc_pkg;

  // register widths, fixed by the register map
  localparam int CFG_W     = 16;
  localparam int RADIUS_W  = 10;
  localparam int COLOR_W   = 16;
  localparam int CFG_IDX_W = 3;

  // register reset values
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 10'd16;
  localparam logic [COLOR_W-1:0]  COLOR_RESET  = 16'hFFFF;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X    = 3'd0,
    REG_START_Y    = 3'd1,
    REG_END_X      = 3'd2,
    REG_END_Y      = 3'd3,
    REG_RADIUS     = 3'd4,
    REG_LINE_COLOR = 3'd5
  } cfg_reg_t;

  // projection factor clamp flags
  typedef struct packed {
    logic clamp_lo;
    logic clamp_hi;
  } proj_mode_t;

endpackage

// ===== design/thick_line_capsule_test_top.sv =====
// Top level of the thick line capsule test: registers, front, divider, back.
// Depends on tlc_pkg, tlc_front, tlc_div_stage and tlc_back.
//
//   channel   signals                                  handshake
//   ------    ---------------------------------------  ---------------------
//   pixel in  pixel_x, pixel_y                         start high, busy low
//   result    out_x, out_y, covered, out_color         done, one cycle
//   config    cfg_index, cfg_data                      cfg_we
//
// One pixel is taken every cycle; busy is never raised.
// The pipeline has five front stages, one divider stage per projection
// fraction bit, and four back stages.
// Reset clears the valid bits and loads the register defaults.
// Results cannot be held off; each is shown for one cycle with done.
module thick_line_capsule_test_top import tlc_pkg::*; #(
  parameter int COORD_FRAC_BITS = 4,
  parameter int PIXEL_BITS      = 12,
  parameter int PROJ_FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [PIXEL_BITS-1:0] pixel_x,
  input  logic signed [PIXEL_BITS-1:0] pixel_y,
  output logic                         done,
  output logic signed [PIXEL_BITS-1:0] out_x,
  output logic signed [PIXEL_BITS-1:0] out_y,
  output logic                         covered,
  output logic [COLOR_W-1:0]           out_color,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_data
);

  localparam int SCALED_W = PIXEL_BITS + COORD_FRAC_BITS;
  localparam int PA_W     = ((SCALED_W > CFG_W) ? SCALED_W : CFG_W) + 1;
  localparam int BA_W     = CFG_W + 1;
  localparam int DOT_W    = PA_W + BA_W + 1;
  localparam int LEN_W    = 2 * BA_W;
  localparam int DX_W     = ((PA_W > BA_W + 1) ? PA_W : BA_W + 1) + 1;
  localparam int MODE_W   = $bits(proj_mode_t);
  localparam int SIDE_W   = 2 * PIXEL_BITS + 2 * PA_W + MODE_W;

  logic signed [CFG_W-1:0] start_x, start_y, end_x, end_y;
  logic [RADIUS_W-1:0]     radius;
  logic [COLOR_W-1:0]      line_color;
  logic signed [BA_W-1:0]  seg_bx, seg_by;

  logic                         f_valid;
  logic signed [PIXEL_BITS-1:0] f_px, f_py;
  logic signed [PA_W-1:0]       f_pax, f_pay;
  proj_mode_t                   f_mode;
  logic [LEN_W-1:0]             f_rem, den;

  logic                      dv    [0:PROJ_FRAC_BITS];
  logic [LEN_W-1:0]          drem  [0:PROJ_FRAC_BITS];
  logic [PROJ_FRAC_BITS-1:0] dq    [0:PROJ_FRAC_BITS];
  logic [SIDE_W-1:0]         dside [0:PROJ_FRAC_BITS];

  logic signed [PIXEL_BITS-1:0] b_px, b_py;
  logic signed [PA_W-1:0]       b_pax, b_pay;
  proj_mode_t                   b_mode;

  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x    <= '0;
      start_y    <= '0;
      end_x      <= '0;
      end_y      <= '0;
      radius     <= RADIUS_RESET;
      line_color <= COLOR_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_X:    start_x    <= cfg_data;
        REG_START_Y:    start_y    <= cfg_data;
        REG_END_X:      end_x      <= cfg_data;
        REG_END_Y:      end_y      <= cfg_data;
        REG_RADIUS:     radius     <= cfg_data[RADIUS_W-1:0];
        REG_LINE_COLOR: line_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // segment vector for the back stages, settled long before any item gets there
  always_ff @(posedge clk) begin
    seg_bx <= BA_W'(end_x) - BA_W'(start_x);
    seg_by <= BA_W'(end_y) - BA_W'(start_y);
  end

  tlc_front #(
    .PIXEL_BITS      (PIXEL_BITS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .PA_W            (PA_W),
    .BA_W            (BA_W),
    .DOT_W           (DOT_W),
    .LEN_W           (LEN_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (f_valid),
    .out_px    (f_px),
    .out_py    (f_py),
    .out_pax   (f_pax),
    .out_pay   (f_pay),
    .out_mode  (f_mode),
    .out_rem   (f_rem),
    .den       (den)
  );

  // divider chain, one quotient bit per stage
  assign dv[0]    = f_valid;
  assign drem[0]  = f_rem;
  assign dq[0]    = '0;
  assign dside[0] = {f_px, f_py, f_pax, f_pay, f_mode};

  for (genvar i = 0; i < PROJ_FRAC_BITS; i++) begin : g_div
    tlc_div_stage #(
      .DEN_W  (LEN_W),
      .Q_W    (PROJ_FRAC_BITS),
      .SIDE_W (SIDE_W)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv[i]),
      .in_rem    (drem[i]),
      .in_q      (dq[i]),
      .in_side   (dside[i]),
      .den       (den),
      .out_valid (dv[i+1]),
      .out_rem   (drem[i+1]),
      .out_q     (dq[i+1]),
      .out_side  (dside[i+1])
    );
  end

  assign {b_px, b_py, b_pax, b_pay, b_mode} = dside[PROJ_FRAC_BITS];

  tlc_back #(
    .PIXEL_BITS     (PIXEL_BITS),
    .PROJ_FRAC_BITS (PROJ_FRAC_BITS),
    .PA_W           (PA_W),
    .BA_W           (BA_W),
    .DX_W           (DX_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (dv[PROJ_FRAC_BITS]),
    .in_mode    (b_mode),
    .in_q       (dq[PROJ_FRAC_BITS]),
    .in_px      (b_px),
    .in_py      (b_py),
    .in_pax     (b_pax),
    .in_pay     (b_pay),
    .bax        (seg_bx),
    .bay        (seg_by),
    .radius     (radius),
    .line_color (line_color),
    .done       (done),
    .out_x      (out_x),
    .out_y      (out_y),
    .covered    (covered),
    .out_color  (out_color)
  );

endmodule

// ===== design/tlc_front.sv =====
// Front stages: pixel offsets, dot product, squared length, clamp decision.
// Depends on tlc_pkg.
module tlc_front import tlc_pkg::*; #(
  parameter int PIXEL_BITS      = 12,
  parameter int COORD_FRAC_BITS = 4,
  parameter int PA_W            = 17,
  parameter int BA_W            = 17,
  parameter int DOT_W           = 35,
  parameter int LEN_W           = 34
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic signed [PIXEL_BITS-1:0] pixel_x,
  input  logic signed [PIXEL_BITS-1:0] pixel_y,
  input  logic signed [CFG_W-1:0]      start_x,
  input  logic signed [CFG_W-1:0]      start_y,
  input  logic signed [CFG_W-1:0]      end_x,
  input  logic signed [CFG_W-1:0]      end_y,
  output logic                         out_valid,
  output logic signed [PIXEL_BITS-1:0] out_px,
  output logic signed [PIXEL_BITS-1:0] out_py,
  output logic signed [PA_W-1:0]       out_pax,
  output logic signed [PA_W-1:0]       out_pay,
  output proj_mode_t                   out_mode,
  output logic [LEN_W-1:0]             out_rem,
  output logic [LEN_W-1:0]             den
);

  localparam int PROD_W = PA_W + BA_W;
  localparam int SQ_W   = 2 * BA_W;

  logic v1, v2, v3, v4;
  logic signed [PIXEL_BITS-1:0] px1, py1, px2, py2, px3, py3, px4, py4;
  logic signed [PA_W-1:0]       pax2, pay2, pax3, pay3, pax4, pay4;
  logic signed [BA_W-1:0]       bax2, bay2;
  logic signed [PROD_W-1:0]     dpx3, dpy3;
  logic signed [SQ_W-1:0]       sqx3, sqy3;
  logic signed [DOT_W-1:0]      dot4;
  logic [LEN_W-1:0]             len4;
  logic signed [PA_W-1:0]       px_ext, py_ext;
  logic                         dot_low, dot_high;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // stage 1: capture the pixel
  always_ff @(posedge clk) begin
    px1 <= pixel_x;
    py1 <= pixel_y;
  end

  // stage 2: offsets from the start point, segment vector
  assign px_ext = PA_W'(px1);
  assign py_ext = PA_W'(py1);

  always_ff @(posedge clk) begin
    px2  <= px1;
    py2  <= py1;
    pax2 <= (px_ext <<< COORD_FRAC_BITS) - PA_W'(start_x);
    pay2 <= (py_ext <<< COORD_FRAC_BITS) - PA_W'(start_y);
    bax2 <= BA_W'(end_x) - BA_W'(start_x);
    bay2 <= BA_W'(end_y) - BA_W'(start_y);
  end

  // stage 3: products
  always_ff @(posedge clk) begin
    px3  <= px2;
    py3  <= py2;
    pax3 <= pax2;
    pay3 <= pay2;
    dpx3 <= pax2 * bax2;
    dpy3 <= pay2 * bay2;
    sqx3 <= bax2 * bax2;
    sqy3 <= bay2 * bay2;
  end

  // stage 4: dot product and squared length
  always_ff @(posedge clk) begin
    px4  <= px3;
    py4  <= py3;
    pax4 <= pax3;
    pay4 <= pay3;
    dot4 <= DOT_W'(dpx3) + DOT_W'(dpy3);
    len4 <= LEN_W'($unsigned(sqx3)) + LEN_W'($unsigned(sqy3));
  end

  // stage 5: clamp decision, divider seed
  assign dot_low  = dot4[DOT_W-1] || (dot4 == '0) || (len4 == '0);
  assign dot_high = dot4 >= $signed(DOT_W'(len4));

  always_ff @(posedge clk) begin
    out_px            <= px4;
    out_py            <= py4;
    out_pax           <= pax4;
    out_pay           <= pay4;
    out_mode.clamp_lo <= dot_low;
    out_mode.clamp_hi <= !dot_low && dot_high;
    out_rem           <= (dot_low || dot_high) ? '0 : LEN_W'($unsigned(dot4));
    den               <= len4;
  end

endmodule

// ===== design/tlc_div_stage.sv =====
// One restoring division step: one quotient bit of the projection factor.
// Depends on tlc_pkg (house import only).
module tlc_div_stage import tlc_pkg::*; #(
  parameter int DEN_W  = 34,
  parameter int Q_W    = 16,
  parameter int SIDE_W = 62
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [DEN_W-1:0]  in_rem,
  input  logic [Q_W-1:0]    in_q,
  input  logic [SIDE_W-1:0] in_side,
  input  logic [DEN_W-1:0]  den,
  output logic              out_valid,
  output logic [DEN_W-1:0]  out_rem,
  output logic [Q_W-1:0]    out_q,
  output logic [SIDE_W-1:0] out_side
);

  logic [DEN_W:0] rem2;
  logic [DEN_W:0] diff;
  logic           take;

  // shift, trial subtract
  assign rem2 = {in_rem, 1'b0};
  assign diff = rem2 - {1'b0, den};
  assign take = rem2 >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rem  <= take ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
    out_q    <= {in_q[Q_W-2:0], take};
    out_side <= in_side;
  end

endmodule

// ===== design/tlc_back.sv =====
// Back stages: closest point on the segment, squared distance, coverage.
// Depends on tlc_pkg.
module tlc_back import tlc_pkg::*; #(
  parameter int PIXEL_BITS     = 12,
  parameter int PROJ_FRAC_BITS = 16,
  parameter int PA_W           = 17,
  parameter int BA_W           = 17,
  parameter int DX_W           = 19
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  proj_mode_t                   in_mode,
  input  logic [PROJ_FRAC_BITS-1:0]    in_q,
  input  logic signed [PIXEL_BITS-1:0] in_px,
  input  logic signed [PIXEL_BITS-1:0] in_py,
  input  logic signed [PA_W-1:0]       in_pax,
  input  logic signed [PA_W-1:0]       in_pay,
  input  logic signed [BA_W-1:0]       bax,
  input  logic signed [BA_W-1:0]       bay,
  input  logic [RADIUS_W-1:0]          radius,
  input  logic [COLOR_W-1:0]           line_color,
  output logic                         done,
  output logic signed [PIXEL_BITS-1:0] out_x,
  output logic signed [PIXEL_BITS-1:0] out_y,
  output logic                         covered,
  output logic [COLOR_W-1:0]           out_color
);

  localparam int H_W  = PROJ_FRAC_BITS + 1;
  localparam int M_W  = BA_W + H_W + 1;
  localparam int SQ_W = 2 * DX_W;
  localparam logic signed [M_W-1:0] HALF = M_W'(1) <<< (PROJ_FRAC_BITS - 1);

  logic v1, v2, v3;
  logic [H_W-1:0]               h;
  logic signed [M_W-1:0]        mx1, my1, rx, ry;
  logic signed [PIXEL_BITS-1:0] px1, py1, px2, py2, px3, py3;
  logic signed [PA_W-1:0]       pax1, pay1;
  logic signed [DX_W-1:0]       dx2, dy2;
  logic signed [SQ_W-1:0]       sqx3, sqy3;
  logic [2*RADIUS_W-1:0]        r2_3;
  logic [SQ_W:0]                dist2;
  logic                         cov;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  // stage 1: clamped factor times segment vector
  always_comb begin
    if (in_mode.clamp_hi) begin
      h = H_W'(1) << PROJ_FRAC_BITS;
    end else if (in_mode.clamp_lo) begin
      h = '0;
    end else begin
      h = {1'b0, in_q};
    end
  end

  always_ff @(posedge clk) begin
    px1  <= in_px;
    py1  <= in_py;
    pax1 <= in_pax;
    pay1 <= in_pay;
    mx1  <= bax * $signed({1'b0, h});
    my1  <= bay * $signed({1'b0, h});
  end

  // stage 2: round to nearest, halves up, and take the offset
  assign rx = mx1 + HALF;
  assign ry = my1 + HALF;

  always_ff @(posedge clk) begin
    px2 <= px1;
    py2 <= py1;
    dx2 <= DX_W'(pax1) - DX_W'(rx >>> PROJ_FRAC_BITS);
    dy2 <= DX_W'(pay1) - DX_W'(ry >>> PROJ_FRAC_BITS);
  end

  // stage 3: squares
  always_ff @(posedge clk) begin
    px3  <= px2;
    py3  <= py2;
    sqx3 <= dx2 * dx2;
    sqy3 <= dy2 * dy2;
    r2_3 <= radius * radius;
  end

  // stage 4: strict compare against radius squared
  assign dist2 = (SQ_W + 1)'($unsigned(sqx3)) + (SQ_W + 1)'($unsigned(sqy3));
  assign cov   = dist2 < (SQ_W + 1)'(r2_3);

  always_ff @(posedge clk) begin
    out_x     <= px3;
    out_y     <= py3;
    covered   <= cov;
    out_color <= cov ? line_color : '0;
  end

endmodule

// ===== sim/tb_thick_line_capsule_test_top.sv =====
// Self-checking testbench for the thick line capsule test: drives pixels and
// register writes, predicts coverage per pixel and checks every result.
// Depends on tlc_pkg and thick_line_capsule_test_top.
module tb_thick_line_capsule_test_top import tlc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIX_W        = 12;
  localparam int COORD_FRAC   = 4;
  localparam int PROJ_FRAC    = 16;
  localparam int PIPE_LATENCY = 9 + PROJ_FRAC;
  localparam int RUN_LIMIT    = 200000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 140;

  // indexes outside the register map; writes to them must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct {
    logic signed [PIX_W-1:0] x;
    logic signed [PIX_W-1:0] y;
    logic                    cov;
    logic [COLOR_W-1:0]      color;
  } pixel_result_t;

  // line registers mirror, coverage prediction and result checking
  class capsule_scoreboard;
    logic signed [CFG_W-1:0] seg_x0, seg_y0, seg_x1, seg_y1;
    logic [RADIUS_W-1:0]     half_width;
    logic [COLOR_W-1:0]      color;
    pixel_result_t           expected_pixels[$];
    int                      mismatch_count;

    function new();
      seg_x0 = '0;
      seg_y0 = '0;
      seg_x1 = '0;
      seg_y1 = '0;
      half_width = RADIUS_RESET;
      color = COLOR_RESET;
      mismatch_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_START_X:    seg_x0 = data;
        REG_START_Y:    seg_y0 = data;
        REG_END_X:      seg_x1 = data;
        REG_END_Y:      seg_y1 = data;
        REG_RADIUS:     half_width = data[RADIUS_W-1:0];
        REG_LINE_COLOR: color = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // closest point on the segment via clamped projection, then distance test
    function void note_pixel(logic signed [PIX_W-1:0] px, logic signed [PIX_W-1:0] py);
      longint pax, pay, bax, bay, dot, len2, h, dx, dy, dist2, r2;
      pixel_result_t res;
      pax = longint'(px) * (longint'(1) <<< COORD_FRAC) - longint'(seg_x0);
      pay = longint'(py) * (longint'(1) <<< COORD_FRAC) - longint'(seg_y0);
      bax = longint'(seg_x1) - longint'(seg_x0);
      bay = longint'(seg_y1) - longint'(seg_y0);
      dot = pax * bax + pay * bay;
      len2 = bax * bax + bay * bay;
      if (dot <= 0 || len2 == 0) begin
        h = 0;
      end else if (dot >= len2) begin
        h = longint'(1) <<< PROJ_FRAC;
      end else begin
        h = (dot <<< PROJ_FRAC) / len2;
      end
      // round to nearest, halves upward: arithmetic shift floors
      dx = pax - ((bax * h + (longint'(1) <<< (PROJ_FRAC - 1))) >>> PROJ_FRAC);
      dy = pay - ((bay * h + (longint'(1) <<< (PROJ_FRAC - 1))) >>> PROJ_FRAC);
      dist2 = dx * dx + dy * dy;
      r2 = longint'(half_width) * longint'(half_width);
      res.x = px;
      res.y = py;
      res.cov = (dist2 < r2);
      res.color = res.cov ? color : '0;
      expected_pixels.push_back(res);
    endfunction

    function void compare_field(string field, longint want, longint got);
      if (want != got) begin
        mismatch_count++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(logic signed [PIX_W-1:0] x, logic signed [PIX_W-1:0] y,
                               logic cov, logic [COLOR_W-1:0] col);
      pixel_result_t want;
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result with no pixel pending, expected none, actual (%0d,%0d)",
                 $time, x, y);
      end else begin
        want = expected_pixels.pop_front();
        compare_field("out_x", want.x, x);
        compare_field("out_y", want.y, y);
        compare_field("covered", want.cov, cov);
        compare_field("out_color", want.color, col);
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [PIX_W-1:0] pixel_x = '0;
  logic signed [PIX_W-1:0] pixel_y = '0;
  logic                    done;
  logic signed [PIX_W-1:0] out_x;
  logic signed [PIX_W-1:0] out_y;
  logic                    covered;
  logic [COLOR_W-1:0]      out_color;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;
  int                      cycle_count = 0;

  capsule_scoreboard sb = new();

  thick_line_capsule_test_top #(
    .COORD_FRAC_BITS(COORD_FRAC),
    .PIXEL_BITS     (PIX_W),
    .PROJ_FRAC_BITS (PROJ_FRAC)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .pixel_x  (pixel_x),
    .pixel_y  (pixel_y),
    .done     (done),
    .out_x    (out_x),
    .out_y    (out_y),
    .covered  (covered),
    .out_color(out_color),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result(out_x, out_y, covered, out_color);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("tb_thick_line_capsule_test_top: FAIL");
      $finish;
    end
  end

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // one register write; the caller lowers cfg_we after the last one
  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic program_line(logic [CFG_W-1:0] x0, logic [CFG_W-1:0] y0,
                              logic [CFG_W-1:0] x1, logic [CFG_W-1:0] y1,
                              logic [CFG_W-1:0] rad_word, logic [CFG_W-1:0] col);
    put_reg(REG_START_X, x0);
    put_reg(REG_START_Y, y0);
    put_reg(REG_END_X, x1);
    put_reg(REG_END_Y, y1);
    put_reg(REG_RADIUS, rad_word);
    put_reg(REG_LINE_COLOR, col);
    put_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(logic signed [PIX_W-1:0] x, logic signed [PIX_W-1:0] y);
    pixel_x <= x;
    pixel_y <= y;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_pixel(x, y);
  endtask

  task automatic idle(int n);
    start <= 1'b0;
    pixel_x <= PIX_W'($urandom);
    pixel_y <= PIX_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // hold the sender off until every pending pixel has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // pixel within the radius plus two pixels, per axis, of a random point on the current segment
  function automatic void pick_near(output logic signed [PIX_W-1:0] px,
                                    output logic signed [PIX_W-1:0] py);
    int t, reach, cx, cy;
    t = $urandom_range(256);
    cx = int'(sb.seg_x0) + ((int'(sb.seg_x1) - int'(sb.seg_x0)) * t) / 256;
    cy = int'(sb.seg_y0) + ((int'(sb.seg_y1) - int'(sb.seg_y0)) * t) / 256;
    reach = (int'(sb.half_width) >>> COORD_FRAC) + 2;
    cx = (cx >>> COORD_FRAC) + int'($urandom_range(2 * reach)) - reach;
    cy = (cy >>> COORD_FRAC) + int'($urandom_range(2 * reach)) - reach;
    px = PIX_W'(clamp(cx, -2048, 2047));
    py = PIX_W'(clamp(cy, -2048, 2047));
  endfunction

  // random segment: free, short, zero-length or axis aligned
  task automatic random_line(int phase);
    logic [CFG_W-1:0]    x0, y0, x1, y1;
    logic [RADIUS_W-1:0] rad;
    int                  dx, dy;
    x0 = CFG_W'($urandom);
    y0 = CFG_W'($urandom);
    dx = int'($urandom_range(4096)) - 2048;
    dy = int'($urandom_range(4096)) - 2048;
    case ($urandom_range(3))
      0: begin
        x1 = CFG_W'($urandom);
        y1 = CFG_W'($urandom);
      end
      1: begin
        x1 = CFG_W'(clamp(int'($signed(x0)) + dx, -32768, 32767));
        y1 = CFG_W'(clamp(int'($signed(y0)) + dy, -32768, 32767));
      end
      2: begin
        x1 = x0;
        y1 = y0;
      end
      default: begin
        x1 = $urandom_range(1) ? CFG_W'(clamp(int'($signed(x0)) + dx, -32768, 32767)) : x0;
        y1 = (x1 == x0) ? CFG_W'(clamp(int'($signed(y0)) + dy, -32768, 32767)) : y0;
      end
    endcase
    if (phase == 0)
      rad = 10'd1023;
    else if (phase == 1)
      rad = 10'd0;
    else if ($urandom_range(2) == 0)
      rad = RADIUS_W'($urandom_range(64));
    else
      rad = RADIUS_W'($urandom_range(1023));
    program_line(x0, y0, x1, y1, {6'($urandom), rad}, CFG_W'($urandom));
  endtask

  task automatic run_phase(int n_items, bit calm, bit pause_mid);
    logic signed [PIX_W-1:0] px, py;
    for (int k = 0; k < n_items; k++) begin
      if (!calm && $urandom_range(99) < 12)
        idle(1);
      if (pause_mid && k == n_items / 2)
        drain();
      if ($urandom_range(9) < 8) begin
        pick_near(px, py);
      end else begin
        px = PIX_W'($urandom);
        py = PIX_W'($urandom);
      end
      send_pixel(px, py);
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset line: zero-length at the origin, one pixel radius, strict edge
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(0, 1);
    send_pixel(-1, -1);
    send_pixel(2047, 2047);
    send_pixel(-2048, -2048);
    send_pixel(2047, -2048);
    send_pixel(-2048, 2047);
    drain();

    // full-range diagonal, widest radius with stray high bits, black color
    program_line(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h0000);
    send_pixel(-2048, -2048);
    send_pixel(2047, 2047);
    send_pixel(0, 0);
    send_pixel(-2048, 2047);
    send_pixel(2047, -2048);
    drain();

    // horizontal segment: before start, middle, exact radius edge, past end
    program_line(16'h0000, 16'h0000, 16'd160, 16'h0000, 16'd32, 16'hA5A5);
    send_pixel(-3, 0);
    send_pixel(-1, 0);
    send_pixel(5, 1);
    send_pixel(5, 2);
    send_pixel(12, 0);
    send_pixel(11, 0);
    drain();

    // zero radius covers nothing, not even the start point
    program_line(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFC00, 16'h1234);
    send_pixel(0, 0);
    drain();

    // random lines, one phase without gaps, one with a pause midway
    for (int p = 0; p < PHASES; p++) begin
      random_line(p);
      run_phase(PHASE_ITEMS, p == 3, p == 5);
    end

    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0)
      $display("tb_thick_line_capsule_test_top: PASS");
    else
      $display("tb_thick_line_capsule_test_top: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
design/tlc_pkg.sv
design/tlc_front.sv
design/tlc_div_stage.sv
design/tlc_back.sv
design/thick_line_capsule_test_top.sv
sim/tb_thick_line_capsule_test_top.sv
